/* sv/vsc_pkg.sv */
// Shared widths, status codes and sideband type for the speed clamp.
`default_nettype none
package vsc_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int LIM_W      = 16;
    localparam int SPD_W      = COMP_WIDTH;
    localparam int RAD_W      = 2 * COMP_WIDTH;
    localparam int SQ_REM_W   = COMP_WIDTH + 2;
    localparam int NUM_W      = COMP_WIDTH + LIM_W;
    localparam int CMP_W      = (COMP_WIDTH > LIM_W) ? COMP_WIDTH : LIM_W;
    localparam int IN_W       = ((2 * COMP_WIDTH + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * COMP_WIDTH + 2 + 7) / 8) * 8;

    localparam logic [1:0] ST_KEEP  = 2'd0;
    localparam logic [1:0] ST_RAISE = 2'd1;
    localparam logic [1:0] ST_LOWER = 2'd2;

    // configuration register indexes
    localparam logic CFG_MIN = 1'b0;
    localparam logic CFG_MAX = 1'b1;

    typedef struct packed {
        logic [COMP_WIDTH-1:0] raw_x;
        logic [COMP_WIDTH-1:0] raw_y;
        logic                  neg_x;
        logic                  neg_y;
        logic [COMP_WIDTH-1:0] mag_x;
        logic [COMP_WIDTH-1:0] mag_y;
        logic [SPD_W-1:0]      speed;
        logic [1:0]            status;
    } side_t;

endpackage
`default_nettype wire

/* sv/vsc_sqrt_cell.sv */
// One digit of the pipelined integer square root: two radicand bits in, one root bit out.
`default_nettype none
module vsc_sqrt_cell (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [vsc_pkg::SQ_REM_W-1:0]  rem_in,
    input  wire logic [vsc_pkg::SPD_W-1:0]     root_in,
    input  wire logic [vsc_pkg::RAD_W-1:0]     rad_in,
    output logic      [vsc_pkg::SQ_REM_W-1:0]  rem_reg,
    output logic      [vsc_pkg::SPD_W-1:0]     root_reg,
    output logic      [vsc_pkg::RAD_W-1:0]     rad_reg
);
    import vsc_pkg::*;

    logic [SQ_REM_W+1:0] shifted;
    logic [SQ_REM_W+1:0] trial;
    logic                ge;
    logic [SQ_REM_W+1:0] diff;

    // bring down the next two radicand bits and try root*4+1
    always_comb
    begin
        shifted = {rem_in, rad_in[RAD_W-1 -: 2]};
        trial   = {{(SQ_REM_W-SPD_W){1'b0}}, root_in, 2'b01};
        ge      = (shifted >= trial);
        diff    = shifted - trial;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= ge ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
            root_reg <= {root_in[SPD_W-2:0], ge};
            rad_reg  <= {rad_in[RAD_W-3:0], 2'b00};
        end
    end

endmodule
`default_nettype wire

/* sv/vsc_div_cell.sv */
// One step of the pipelined restoring divider: one quotient bit per cell.
`default_nettype none
module vsc_div_cell (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [vsc_pkg::SPD_W-1:0]  divisor,
    input  wire logic [vsc_pkg::SPD_W-1:0]  rem_in,
    input  wire logic [vsc_pkg::NUM_W-1:0]  num_in,
    input  wire logic [vsc_pkg::NUM_W-1:0]  quo_in,
    output logic      [vsc_pkg::SPD_W-1:0]  rem_reg,
    output logic      [vsc_pkg::NUM_W-1:0]  num_reg,
    output logic      [vsc_pkg::NUM_W-1:0]  quo_reg
);
    import vsc_pkg::*;

    logic [SPD_W:0] shifted;
    logic [SPD_W:0] diff;
    logic           ge;

    // shift in the next dividend bit and subtract if it fits
    always_comb
    begin
        shifted = {rem_in, num_in[NUM_W-1]};
        diff    = shifted - {1'b0, divisor};
        ge      = (shifted >= {1'b0, divisor});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? diff[SPD_W-1:0] : shifted[SPD_W-1:0];
            num_reg <= {num_in[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_in[NUM_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

/* sv/vector_speed_clamp_2d.sv */
// Top level: 2D velocity magnitude clamp built as a row of sqrt and divider cells.
// Throughput: one vector per cycle while m_tready does not stall the output;
// each sqrt and divider cell retires one bit per cycle.
// Stages advance independently, so bubbles close up while the output waits.
// Reset (rst_n low, async): all stages empty, min_speed 0, max_speed 65535.
`default_nettype none
module vector_speed_clamp_2d (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_addr,
    input  wire logic [15:0]                cfg_wdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // tdata: vel_x, vel_y
    input  wire logic [vsc_pkg::IN_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // tdata: out_x, out_y, clamp_status, zero pad
    output logic      [vsc_pkg::OUT_W-1:0]  m_tdata
);
    import vsc_pkg::*;

    localparam int CW     = COMP_WIDTH;
    localparam int SQ0    = 3;
    localparam int DEC    = SQ0 + CW;
    localparam int DV0    = DEC + 1;
    localparam int OST    = DV0 + NUM_W;
    localparam int NST    = OST + 1;
    localparam logic [NUM_W-1:0] HALF = {{(NUM_W-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

    logic [15:0]      min_reg;
    logic [15:0]      max_reg;
    logic [NST-1:0]   valid_reg;
    logic [NST-1:0]   en;
    side_t            side_reg [OST];
    side_t            side_next [OST];

    logic [RAD_W-1:0] sqx_reg;
    logic [RAD_W-1:0] sqy_reg;
    logic [RAD_W-1:0] sum_reg;
    logic [NUM_W-1:0] prodx_reg;
    logic [NUM_W-1:0] prody_reg;

    logic [SQ_REM_W-1:0] sq_rem  [CW];
    logic [SPD_W-1:0]    sq_root [CW];
    logic [RAD_W-1:0]    sq_rad  [CW];

    logic [SPD_W-1:0] dx_rem [NUM_W];
    logic [NUM_W-1:0] dx_num [NUM_W];
    logic [NUM_W-1:0] dx_quo [NUM_W];
    logic [SPD_W-1:0] dy_rem [NUM_W];
    logic [NUM_W-1:0] dy_num [NUM_W];
    logic [NUM_W-1:0] dy_quo [NUM_W];

    logic [CW-1:0]    in_x;
    logic [CW-1:0]    in_y;
    logic [CMP_W-1:0] spd_c;
    logic [CMP_W-1:0] min_c;
    logic [CMP_W-1:0] max_c;
    logic [1:0]       dec_status;
    logic [LIM_W-1:0] dec_limit;
    logic [CW-1:0]    sat_x;
    logic [CW-1:0]    sat_y;
    logic [CW-1:0]    out_x_reg;
    logic [CW-1:0]    out_y_reg;
    logic [1:0]       out_st_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= 16'd0;
            max_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MIN: min_reg <= cfg_wdata;
                CFG_MAX: max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-stage advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // decide: raise, lower or keep
    assign in_x  = s_tdata[CW-1:0];
    assign in_y  = s_tdata[2*CW-1:CW];
    assign spd_c = CMP_W'(sq_root[CW-1]);
    assign min_c = CMP_W'(min_reg);
    assign max_c = CMP_W'(max_reg);

    always_comb
    begin
        dec_status = ST_KEEP;
        dec_limit  = '0;
        if (spd_c != '0)
        begin
            if (spd_c < min_c)
            begin
                dec_status = ST_RAISE;
                dec_limit  = min_reg;
            end
            else if (spd_c > max_c)
            begin
                dec_status = ST_LOWER;
                dec_limit  = max_reg;
            end
        end
    end

    // sideband that rides along the row
    always_comb
    begin
        side_next[0].raw_x  = in_x;
        side_next[0].raw_y  = in_y;
        side_next[0].neg_x  = in_x[CW-1];
        side_next[0].neg_y  = in_y[CW-1];
        side_next[0].mag_x  = in_x[CW-1] ? (~in_x + 1'b1) : in_x;
        side_next[0].mag_y  = in_y[CW-1] ? (~in_y + 1'b1) : in_y;
        side_next[0].speed  = '0;
        side_next[0].status = ST_KEEP;
        for (int k = 1; k < OST; k++)
        begin
            if (k == DEC)
            begin
                side_next[k]        = side_reg[k-1];
                side_next[k].speed  = sq_root[CW-1];
                side_next[k].status = dec_status;
            end
            else
                side_next[k] = side_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < OST; k++)
        begin
            if (en[k])
                side_reg[k] <= side_next[k];
        end
    end

    // squares, sum, limit products
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sqx_reg <= RAD_W'(side_reg[0].mag_x * side_reg[0].mag_x);
            sqy_reg <= RAD_W'(side_reg[0].mag_y * side_reg[0].mag_y);
        end
        if (en[2])
            sum_reg <= sqx_reg + sqy_reg;
        if (en[DEC])
        begin
            prodx_reg <= NUM_W'(side_reg[DEC-1].mag_x * dec_limit);
            prody_reg <= NUM_W'(side_reg[DEC-1].mag_y * dec_limit);
        end
    end

    // square root cells
    genvar j;
    generate
        for (j = 0; j < CW; j++)
        begin : g_sqrt
            if (j == 0)
            begin : g_first
                vsc_sqrt_cell u_cell (
                    .clk      (clk),
                    .en       (en[SQ0+j]),
                    .rem_in   ('0),
                    .root_in  ('0),
                    .rad_in   (sum_reg),
                    .rem_reg  (sq_rem[j]),
                    .root_reg (sq_root[j]),
                    .rad_reg  (sq_rad[j])
                );
            end
            else
            begin : g_rest
                vsc_sqrt_cell u_cell (
                    .clk      (clk),
                    .en       (en[SQ0+j]),
                    .rem_in   (sq_rem[j-1]),
                    .root_in  (sq_root[j-1]),
                    .rad_in   (sq_rad[j-1]),
                    .rem_reg  (sq_rem[j]),
                    .root_reg (sq_root[j]),
                    .rad_reg  (sq_rad[j])
                );
            end
        end
    endgenerate

    // divider cells, one row per component
    genvar i;
    generate
        for (i = 0; i < NUM_W; i++)
        begin : g_div
            if (i == 0)
            begin : g_first
                vsc_div_cell u_dx (
                    .clk     (clk),
                    .en      (en[DV0+i]),
                    .divisor (side_reg[DV0+i-1].speed),
                    .rem_in  ('0),
                    .num_in  (prodx_reg),
                    .quo_in  ('0),
                    .rem_reg (dx_rem[i]),
                    .num_reg (dx_num[i]),
                    .quo_reg (dx_quo[i])
                );
                vsc_div_cell u_dy (
                    .clk     (clk),
                    .en      (en[DV0+i]),
                    .divisor (side_reg[DV0+i-1].speed),
                    .rem_in  ('0),
                    .num_in  (prody_reg),
                    .quo_in  ('0),
                    .rem_reg (dy_rem[i]),
                    .num_reg (dy_num[i]),
                    .quo_reg (dy_quo[i])
                );
            end
            else
            begin : g_rest
                vsc_div_cell u_dx (
                    .clk     (clk),
                    .en      (en[DV0+i]),
                    .divisor (side_reg[DV0+i-1].speed),
                    .rem_in  (dx_rem[i-1]),
                    .num_in  (dx_num[i-1]),
                    .quo_in  (dx_quo[i-1]),
                    .rem_reg (dx_rem[i]),
                    .num_reg (dx_num[i]),
                    .quo_reg (dx_quo[i])
                );
                vsc_div_cell u_dy (
                    .clk     (clk),
                    .en      (en[DV0+i]),
                    .divisor (side_reg[DV0+i-1].speed),
                    .rem_in  (dy_rem[i-1]),
                    .num_in  (dy_num[i-1]),
                    .quo_in  (dy_quo[i-1]),
                    .rem_reg (dy_rem[i]),
                    .num_reg (dy_num[i]),
                    .quo_reg (dy_quo[i])
                );
            end
        end
    endgenerate

    // sign restore with saturation
    always_comb
    begin
        if (side_reg[OST-1].neg_x)
            sat_x = (dx_quo[NUM_W-1] > HALF) ? {1'b1, {(CW-1){1'b0}}}
                                              : CW'(~dx_quo[NUM_W-1] + 1'b1);
        else
            sat_x = (dx_quo[NUM_W-1] > HALF - 1'b1) ? {1'b0, {(CW-1){1'b1}}}
                                                     : dx_quo[NUM_W-1][CW-1:0];
        if (side_reg[OST-1].neg_y)
            sat_y = (dy_quo[NUM_W-1] > HALF) ? {1'b1, {(CW-1){1'b0}}}
                                              : CW'(~dy_quo[NUM_W-1] + 1'b1);
        else
            sat_y = (dy_quo[NUM_W-1] > HALF - 1'b1) ? {1'b0, {(CW-1){1'b1}}}
                                                     : dy_quo[NUM_W-1][CW-1:0];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en[OST])
        begin
            if (side_reg[OST-1].status == ST_KEEP)
            begin
                out_x_reg <= side_reg[OST-1].raw_x;
                out_y_reg <= side_reg[OST-1].raw_y;
            end
            else
            begin
                out_x_reg <= sat_x;
                out_y_reg <= sat_y;
            end
            out_st_reg <= side_reg[OST-1].status;
        end
    end

    assign m_tdata = OUT_W'({out_st_reg, out_y_reg, out_x_reg});

endmodule
`default_nettype wire
